// ----- hw/rtl/prc_pkg.sv -----
`default_nettype none
package prc_pkg;
    localparam int RULE_COUNT_DEF = 16;
    localparam int LIST_SLOTS_DEF = 4;
    localparam logic [7:0] PROTO_NEVER = 8'd252;

    typedef enum logic [1:0] {
        CMD_CLASSIFY = 2'd0,
        CMD_ADDR_WR  = 2'd1,
        CMD_PORT_WR  = 2'd2,
        CMD_HDR_WR   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  rule_index;
        logic [1:0]  list_select;
        logic [1:0]  slot_index;
        logic        entry_valid;
        logic [1:0]  any_flags;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        is_icmp;
    } req_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] hit_rule;
        logic       write_ack;
    } rsp_t;
endpackage
`default_nettype wire

// ----- hw/rtl/prc_if.sv -----
`default_nettype none
interface prc_req_if;
    import prc_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface prc_rsp_if;
    import prc_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/packet_rule_classifier.sv -----
// Channel | Dir | Payload
// req     | in  | prc_pkg::req_t (command and packet fields)
// rsp     | out | prc_pkg::rsp_t (hit, hit_rule, write_ack)
//
// A write goes from accept to ST_DONE, which loads the result beat into the output register.
// A classify walks the rules in ST_WALK: one rule per cycle is read from the
// rule-wide entry RAMs (registered read), its match is folded once the row is on the RAM outputs.
// rst_n clears headers and entry valid bits at once; no clearing pass.
// A stalled result holds in the output register; no new beat is taken meanwhile.
`default_nettype none
module packet_rule_classifier
    import prc_pkg::*;
#(
    parameter int RULE_COUNT = RULE_COUNT_DEF,
    parameter int LIST_SLOTS = LIST_SLOTS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    prc_req_if.sink  req,
    prc_rsp_if.source rsp
);
    localparam int RW  = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam int NE  = 4 * LIST_SLOTS;          // entries per rule
    localparam int EW  = $clog2(NE);              // entry index within a rule
    localparam int RD  = (RULE_COUNT > 1) ? RULE_COUNT : 2;

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [RW:0] cnt_reg;
    logic        fold_reg;
    logic [RW-1:0] fold_rule_reg;
    logic        hit_reg;
    logic [3:0]  last_reg;
    rsp_t        out_reg;
    logic        out_valid_reg;

    logic [RULE_COUNT-1:0] rule_on_reg;
    logic [7:0]  rule_proto_reg [RULE_COUNT];
    logic [1:0]  rule_any_reg   [RULE_COUNT];
    logic [NE-1:0] aon_reg [RULE_COUNT];
    logic [NE-1:0] pon_reg [RULE_COUNT];

    // Rows hold all entries of one rule; write is read-modify-free via byte
    // lanes would need masks, so keep one RAM per entry slot.
    logic [63:0] arow [NE];
    logic [31:0] prow [NE];

    logic accept;
    logic wr_rule_ok, wr_slot_ok;
    logic [RW-1:0] rd_rule;
    logic [RW-1:0] wr_rule;
    logic [EW-1:0] wr_ent;

    assign accept  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign wr_rule_ok = {{(32-4){1'b0}}, req.data.rule_index} < RULE_COUNT;
    assign wr_slot_ok = {{(32-2){1'b0}}, req.data.slot_index} < LIST_SLOTS;
    assign wr_rule = RW'(req.data.rule_index);
    assign wr_ent = EW'(32'(req.data.list_select) * LIST_SLOTS
                        + 32'(req.data.slot_index));
    assign rd_rule = cnt_reg[RW-1:0];

    genvar g;
    generate
        for (g = 0; g < NE; g++)
        begin : g_ent
            logic wa, wp;
            assign wa = accept && req.data.cmd == CMD_ADDR_WR && wr_rule_ok
                        && wr_slot_ok && wr_ent == EW'(g);
            assign wp = accept && req.data.cmd == CMD_PORT_WR && wr_rule_ok
                        && wr_slot_ok && wr_ent == EW'(g);
            prc_ram #(.WIDTH(64), .DEPTH(RD)) u_addr (
                .clk(clk), .wr_en(wa),
                .wr_addr(($clog2(RD))'(req.data.rule_index)),
                .wr_data({req.data.src_addr, req.data.dst_addr}),
                .rd_addr(($clog2(RD))'(rd_rule)), .rd_data(arow[g]));
            prc_ram #(.WIDTH(32), .DEPTH(RD)) u_port (
                .clk(clk), .wr_en(wp),
                .wr_addr(($clog2(RD))'(req.data.rule_index)),
                .wr_data({req.data.dport, req.data.sport}),
                .rd_addr(($clog2(RD))'(rd_rule)), .rd_data(prow[g]));
        end
    endgenerate

    // Header and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_on_reg <= '0;
            for (int r = 0; r < RULE_COUNT; r++)
            begin
                rule_proto_reg[r] <= '0;
                rule_any_reg[r]   <= '0;
                aon_reg[r]        <= '0;
                pon_reg[r]        <= '0;
            end
        end
        else if (accept && wr_rule_ok)
        begin
            if (req.data.cmd == CMD_HDR_WR)
            begin
                rule_on_reg[wr_rule]    <= req.data.entry_valid;
                rule_proto_reg[wr_rule] <= req.data.proto;
                rule_any_reg[wr_rule]   <= req.data.any_flags;
            end
            else if (req.data.cmd == CMD_ADDR_WR && wr_slot_ok)
            begin
                aon_reg[wr_rule][wr_ent] <= req.data.entry_valid;
            end
            else if (req.data.cmd == CMD_PORT_WR && wr_slot_ok)
            begin
                pon_reg[wr_rule][wr_ent] <= req.data.entry_valid;
            end
        end
    end

    // Match of the rule whose row is on the RAM outputs
    logic [3:0] am;   // per list: some valid entry matches
    logic [3:0] pm;   // list0/2: range hit, list1/3: exact hit
    logic rule_hit;
    always_comb
    begin
        logic [31:0] a, v, m;
        logic [15:0] p, lo, hi;
        am = '0;
        pm = '0;
        for (int l = 0; l < 4; l++)
        begin
            for (int s = 0; s < LIST_SLOTS; s++)
            begin
                a  = (l < 2) ? req_reg.src_addr : req_reg.dst_addr;
                p  = (l < 2) ? req_reg.sport : req_reg.dport;
                v  = arow[l*LIST_SLOTS+s][63:32];
                m  = arow[l*LIST_SLOTS+s][31:0];
                lo = prow[l*LIST_SLOTS+s][15:0];
                hi = prow[l*LIST_SLOTS+s][31:16];
                if (aon_reg[fold_rule_reg][l*LIST_SLOTS+s] && (a & m) == (v & m))
                    am[l] = 1'b1;
                if (pon_reg[fold_rule_reg][l*LIST_SLOTS+s])
                begin
                    if (l[0] ? (lo == p && p == hi) : (lo <= p && p <= hi))
                        pm[l] = 1'b1;
                end
            end
        end
        rule_hit = rule_on_reg[fold_rule_reg] && !am[1] && am[0] && !am[3] && am[2]
            && (req_reg.is_icmp
                || ((rule_any_reg[fold_rule_reg][0] || (!pm[1] && pm[0]))
                 && (rule_any_reg[fold_rule_reg][1] || (!pm[3] && pm[2]))))
            && req_reg.proto == rule_proto_reg[fold_rule_reg]
            && rule_proto_reg[fold_rule_reg] != PROTO_NEVER;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (req.data.cmd == CMD_CLASSIFY) ? ST_WALK : ST_DONE;
            end
            ST_WALK:
            begin
                if (cnt_reg == (RW+1)'(RULE_COUNT))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!fold_reg)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fold_reg      <= 1'b0;
            fold_rule_reg <= '0;
            hit_reg       <= 1'b0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // fold the rule read last cycle
            fold_reg <= (state_reg == ST_WALK) && cnt_reg < (RW+1)'(RULE_COUNT);
            fold_rule_reg <= rd_rule;
            if (fold_reg && rule_hit)
            begin
                hit_reg  <= 1'b1;
                last_reg <= 4'(fold_rule_reg);
            end
            if (accept)
            begin
                cnt_reg  <= '0;
                hit_reg  <= 1'b0;
                last_reg <= '0;
            end
            else if (state_reg == ST_WALK && cnt_reg < (RW+1)'(RULE_COUNT))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_DONE && !fold_reg)
            begin
                out_valid_reg     <= 1'b1;
                out_reg.write_ack <= req_reg.cmd != CMD_CLASSIFY;
                out_reg.hit       <= (req_reg.cmd == CMD_CLASSIFY) && hit_reg;
                out_reg.hit_rule  <= (req_reg.cmd == CMD_CLASSIFY) ? last_reg : 4'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req.data;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/prc_ram.sv -----
`default_nettype none
module prc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/prc_checker.sv -----
`default_nettype none
module prc_checker
    import prc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result beat dropped or changed while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.hit && rsp_data.write_ack))
        else $error("write ack with hit");
    a_norule: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.hit |-> rsp_data.hit_rule == 4'd0)
        else $error("rule index without hit");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("took a beat while busy");
endmodule

bind packet_rule_classifier prc_checker u_prc_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));
`default_nettype wire

// ----- test/prc_checker.sv -----
`timescale 1ns / 100ps
module prc_scoreboard
    import prc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_ready,
    input  req_t      req_data,
    input  wire logic rsp_valid,
    input  wire logic rsp_ready,
    input  rsp_t      rsp_data,
    output int        fail_count,
    output int        pending
);
    localparam int RULES = RULE_COUNT_DEF;
    localparam int SLOTS = LIST_SLOTS_DEF;
    localparam int ENTRIES = RULES * 4 * SLOTS;

    logic        hdr_on [RULES];
    logic [7:0]  hdr_proto [RULES];
    logic [1:0]  hdr_any [RULES];
    logic        addr_on [ENTRIES];
    logic [31:0] addr_val [ENTRIES];
    logic [31:0] addr_msk [ENTRIES];
    logic        port_on [ENTRIES];
    logic [15:0] port_lo [ENTRIES];
    logic [15:0] port_hi [ENTRIES];

    rsp_t verdict_q[$];

    function automatic int base_of(int r, int l);
        return (r * 4 + l) * SLOTS;
    endfunction

    function automatic bit addr_hits(int b, logic [31:0] a);
        for (int s = 0; s < SLOTS; s++)
            if (addr_on[b+s] && ((a & addr_msk[b+s]) == (addr_val[b+s] & addr_msk[b+s])))
                return 1;
        return 0;
    endfunction

    function automatic bit port_ok(int r, int allow, logic [15:0] p);
        int db;
        int ab;
        db = base_of(r, allow + 1);
        ab = base_of(r, allow);
        for (int s = 0; s < SLOTS; s++)
            if (port_on[db+s] && port_lo[db+s] == p && p == port_hi[db+s])
                return 0;
        for (int s = 0; s < SLOTS; s++)
            if (port_on[ab+s] && port_lo[ab+s] <= p && p <= port_hi[ab+s])
                return 1;
        return 0;
    endfunction

    // Update the table on writes, else walk all rules and keep the last hit.
    function automatic rsp_t classify(req_t q);
        rsp_t o;
        int e;
        o = '0;
        if (q.cmd != CMD_CLASSIFY) begin
            o.write_ack = 1'b1;
            if (q.cmd == CMD_HDR_WR) begin
                hdr_on[q.rule_index] = q.entry_valid;
                hdr_proto[q.rule_index] = q.proto;
                hdr_any[q.rule_index] = q.any_flags;
            end else begin
                e = base_of(q.rule_index, q.list_select) + q.slot_index;
                if (q.cmd == CMD_ADDR_WR) begin
                    addr_on[e] = q.entry_valid;
                    addr_val[e] = q.src_addr;
                    addr_msk[e] = q.dst_addr;
                end else begin
                    port_on[e] = q.entry_valid;
                    port_lo[e] = q.sport;
                    port_hi[e] = q.dport;
                end
            end
            return o;
        end
        for (int r = 0; r < RULES; r++) begin
            if (!hdr_on[r]) continue;
            if (addr_hits(base_of(r, 1), q.src_addr)) continue;
            if (!addr_hits(base_of(r, 0), q.src_addr)) continue;
            if (addr_hits(base_of(r, 3), q.dst_addr)) continue;
            if (!addr_hits(base_of(r, 2), q.dst_addr)) continue;
            if (!q.is_icmp) begin
                if (!hdr_any[r][0] && !port_ok(r, 0, q.sport)) continue;
                if (!hdr_any[r][1] && !port_ok(r, 2, q.dport)) continue;
            end
            if (q.proto != hdr_proto[r] || hdr_proto[r] == PROTO_NEVER) continue;
            o.hit = 1'b1;
            o.hit_rule = 4'(r);
        end
        return o;
    endfunction

    assign pending = verdict_q.size();

    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        int errs;
        errs = 0;
        if (!rst_n) begin
            fail_count <= 0;
            verdict_q.delete();
            for (int r = 0; r < RULES; r++) begin
                hdr_on[r] = 0;
                hdr_proto[r] = 0;
                hdr_any[r] = 0;
            end
            for (int e = 0; e < ENTRIES; e++) begin
                addr_on[e] = 0;
                addr_val[e] = 0;
                addr_msk[e] = 0;
                port_on[e] = 0;
                port_lo[e] = 0;
                port_hi[e] = 0;
            end
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with no expectation");
                    errs++;
                end else begin
                    want = verdict_q.pop_front();
                    if (rsp_data.hit !== want.hit) begin
                        $error("hit: expected %0d actual %0d", want.hit, rsp_data.hit);
                        errs++;
                    end
                    if (rsp_data.hit_rule !== want.hit_rule) begin
                        $error("hit_rule: expected %0d actual %0d",
                               want.hit_rule, rsp_data.hit_rule);
                        errs++;
                    end
                    if (rsp_data.write_ack !== want.write_ack) begin
                        $error("write_ack: expected %0d actual %0d",
                               want.write_ack, rsp_data.write_ack);
                        errs++;
                    end
                end
            end
            if (req_valid && req_ready)
                verdict_q.push_back(classify(req_data));
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end
endmodule

// ----- test/packet_rule_classifier_tb.sv -----
`timescale 1ns / 100ps
module packet_rule_classifier_tb;
    import prc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   burst_left;
    int   gap_left;
    bit   in_burst;
    int   stall_mode;

    prc_req_if req_ch ();
    prc_rsp_if rsp_ch ();

    packet_rule_classifier dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    prc_scoreboard checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_ch.valid),
        .req_ready  (req_ch.ready),
        .req_data   (req_ch.data),
        .rsp_valid  (rsp_ch.valid),
        .rsp_ready  (rsp_ch.ready),
        .rsp_data   (rsp_ch.data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Watchdog: count cycles with no beat on either side.
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver backpressure: switch between free flow, light and heavy stall.
    always @(posedge clk) begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic req_t blank_beat();
        req_t q;
        q = '0;
        return q;
    endfunction

    // Send one beat; drop valid for a gap only when a gap is due.
    task automatic send_beat(req_t q);
        if (in_burst && burst_left == 0) begin
            in_burst = 0;
            gap_left = $urandom_range(0, 6);
        end
        if (!in_burst) begin
            if (gap_left > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap_left) @(posedge clk);
            end
            in_burst = 1;
            burst_left = $urandom_range(1, 12);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= q;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        burst_left--;
    endtask

    task automatic write_hdr(int r, bit on, logic [7:0] p, logic [1:0] anyf);
        req_t q;
        q = blank_beat();
        q.cmd = CMD_HDR_WR;
        q.rule_index = 4'(r);
        q.entry_valid = on;
        q.proto = p;
        q.any_flags = anyf;
        send_beat(q);
    endtask

    task automatic write_addr(int r, int l, int s, bit on, logic [31:0] a, logic [31:0] m);
        req_t q;
        q = blank_beat();
        q.cmd = CMD_ADDR_WR;
        q.rule_index = 4'(r);
        q.list_select = 2'(l);
        q.slot_index = 2'(s);
        q.entry_valid = on;
        q.src_addr = a;
        q.dst_addr = m;
        send_beat(q);
    endtask

    task automatic write_port(int r, int l, int s, bit on, logic [15:0] lo, logic [15:0] hi);
        req_t q;
        q = blank_beat();
        q.cmd = CMD_PORT_WR;
        q.rule_index = 4'(r);
        q.list_select = 2'(l);
        q.slot_index = 2'(s);
        q.entry_valid = on;
        q.sport = lo;
        q.dport = hi;
        send_beat(q);
    endtask

    task automatic send_packet(logic [31:0] sa, logic [31:0] da, logic [7:0] p,
                               logic [15:0] sp, logic [15:0] dp, bit icmp);
        req_t q;
        q = blank_beat();
        q.cmd = CMD_CLASSIFY;
        q.src_addr = sa;
        q.dst_addr = da;
        q.proto = p;
        q.sport = sp;
        q.dport = dp;
        q.is_icmp = icmp;
        // Fill unused fields with noise; a classify ignores them.
        q.rule_index = 4'($urandom);
        q.list_select = 2'($urandom);
        q.slot_index = 2'($urandom);
        q.entry_valid = 1'($urandom);
        q.any_flags = 2'($urandom);
        send_beat(q);
    endtask

    // Pick an address near one of a few seeds so masks match often.
    function automatic logic [31:0] near_addr(int k);
        logic [31:0] seeds [4];
        seeds = '{32'h0A000001, 32'hC0A80164, 32'hFFFFFFFF, 32'h00000000};
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return seeds[k % 4] ^ ($urandom_range(0, 1) ? 32'($urandom_range(0, 255)) : 32'h0);
    endfunction

    function automatic logic [31:0] rand_mask();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return 32'hFFFFFF00;
            3: return 32'hFFFF0000;
            default: return $urandom;
        endcase
    endfunction

    // Build a random table: every address entry is written before any classify.
    task automatic load_table();
        for (int r = 0; r < 16; r++)
            for (int l = 0; l < 4; l++)
                for (int s = 0; s < 4; s++) begin
                    write_addr(r, l, s,
                               (l[0] == 0) ? ($urandom_range(0, 2) != 0)
                                           : ($urandom_range(0, 3) == 0),
                               near_addr($urandom_range(0, 3)), rand_mask());
                    write_port(r, l, s, $urandom_range(0, 1),
                               16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1100)),
                               16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1100)));
                end
        for (int r = 0; r < 16; r++)
            write_hdr(r, $urandom_range(0, 4) != 0,
                      8'($urandom_range(0, 5) == 0 ? PROTO_NEVER : $urandom_range(0, 2) * 11 + 6),
                      2'($urandom));
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial begin
        idle_cycles = 0;
        stall_mode = 0;
        in_burst = 0;
        burst_left = 0;
        gap_left = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, then rules 3 and 15 exercised edge by edge.
        send_packet(32'h0, 32'hFFFFFFFF, 8'd6, 16'h0, 16'hFFFF, 1'b0);
        for (int l = 0; l < 4; l++)
            write_addr(3, l, 0, l[0] == 0, 32'h0A000000, 32'hFF000000);
        write_addr(3, 1, 1, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF);
        write_port(3, 0, 0, 1'b1, 16'd0, 16'hFFFF);
        write_port(3, 2, 3, 1'b1, 16'd80, 16'd80);
        write_port(3, 3, 0, 1'b1, 16'hFFFF, 16'hFFFF);
        write_port(3, 2, 1, 1'b1, 16'd500, 16'd100);
        write_hdr(3, 1'b1, 8'd17, 2'b00);
        send_packet(32'h0A0000FF, 32'h0A123456, 8'd17, 16'd0, 16'd80, 1'b0);
        send_packet(32'h0A0000FF, 32'h0A123456, 8'd17, 16'hFFFF, 16'd81, 1'b0);
        send_packet(32'h0A0000FF, 32'h0A123456, 8'd17, 16'hFFFF, 16'd300, 1'b1);
        send_packet(32'h0B000000, 32'h0A000000, 8'd17, 16'd1, 16'd80, 1'b0);
        send_packet(32'h0A000000, 32'h0A000000, 8'd16, 16'd1, 16'd80, 1'b0);
        write_hdr(3, 1'b1, PROTO_NEVER, 2'b11);
        send_packet(32'h0A000000, 32'h0A000000, PROTO_NEVER, 16'd1, 16'd1, 1'b0);
        write_addr(15, 0, 3, 1'b1, 32'h0, 32'h0);
        write_addr(15, 2, 3, 1'b1, 32'hFFFFFFFF, 32'h0);
        write_hdr(15, 1'b1, 8'hFF, 2'b11);
        send_packet(32'hFFFFFFFF, 32'h12345678, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
        write_hdr(15, 1'b0, 8'hFF, 2'b11);
        send_packet(32'hFFFFFFFF, 32'h12345678, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        drain();

        // Random: rebuild the table, then mostly packets aimed at it.
        for (int round = 0; round < 1; round++) begin
            load_table();
            repeat (500) begin
                case ($urandom_range(0, 9))
                    0: write_hdr($urandom_range(0, 15), $urandom_range(0, 1),
                                 8'($urandom), 2'($urandom));
                    1: write_port($urandom_range(0, 15), $urandom_range(0, 3),
                                  $urandom_range(0, 3), $urandom_range(0, 1),
                                  16'($urandom), 16'($urandom));
                    2: write_addr($urandom_range(0, 15), $urandom_range(0, 3),
                                  $urandom_range(0, 3), $urandom_range(0, 1),
                                  near_addr($urandom_range(0, 3)), rand_mask());
                    default: send_packet(near_addr($urandom_range(0, 3)),
                                         near_addr($urandom_range(0, 3)),
                                         8'($urandom_range(0, 7) == 0 ? $urandom
                                                                      : $urandom_range(0, 2) * 11 + 6),
                                         16'($urandom_range(0, 3) == 0 ? $urandom
                                                                       : $urandom_range(0, 1100)),
                                         16'($urandom_range(0, 3) == 0 ? $urandom
                                                                       : $urandom_range(0, 1100)),
                                         $urandom_range(0, 3) == 0);
                endcase
            end
        end

        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/prc_pkg.sv
hw/rtl/prc_if.sv
hw/rtl/prc_ram.sv
hw/rtl/packet_rule_classifier.sv
hw/rtl/prc_checker.sv
test/prc_checker.sv
test/packet_rule_classifier_tb.sv
